@@ rtl/core/csort_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package csort_pkg;

   // Key field width on the stream and the internal key range.
   localparam int KEY_W     = 8;
   localparam int KEY_BITS  = 8;
   localparam int MAX_ITEMS = 64;
   localparam int KEY_RANGE = 1 << KEY_BITS;

   // A counter holds up to MAX_ITEMS inclusive.
   localparam int CNT_BITS  = $clog2(MAX_ITEMS + 1);

   typedef logic [KEY_W-1:0]    key_type;
   typedef logic [KEY_BITS-1:0] addr_type;
   typedef logic [CNT_BITS-1:0] cnt_type;

endpackage : csort_pkg

`default_nettype wire

@@ rtl/core/counting_sort.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | tdata bits (low first)   | tlast          | tuser
// --------+-----+--------------------------+----------------+---------------
// req_    | in  | [7:0] key                | is_last        | -
// rsp_    | out | [7:0] sorted_key         | last_out       | dropped
//
// Load: per key, S_IDLE reads and S_INC writes back the count (no key in S_INC).
// Drain: S_WALK reads key slot zero, then S_CHK steps over each empty key slot
//   and S_EMIT hands out the results of each held key in turn; the walk stops
//   at the largest key held.
// Reset: a clearing pass over all 2^KEY_BITS slots (256) zeroes the count
//   memory while req_tready stays low.
// Stalls: rsp_tready low holds the result register and the walk.
// No key is taken while a set drains.

module counting_sort (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   output logic                req_tready,
   input  csort_pkg::key_type  req_tdata,   // [7:0] key
   input  wire                 req_tlast,   // is_last
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   output csort_pkg::key_type  rsp_tdata,   // [7:0] sorted_key
   output logic                rsp_tlast,   // last_out
   output logic                rsp_tuser    // [0] dropped
);
   import csort_pkg::*;

   typedef enum logic [2:0] {
      S_CLR,    // zero the count memory after reset
      S_IDLE,   // take a key, issue the count read
      S_INC,    // write the count back plus one, unless the key drops
      S_WALK,   // issue the read of key slot zero
      S_CHK,    // look at one count; if nonzero, clear it and start emitting
      S_EMIT    // hand out one key per transaction
   } state_type;

   state_type state_ff;

   // Count memory, one read and one write port, registered read data.
   cnt_type  key_counts_mem [KEY_RANGE];
   cnt_type  rdata_ff;
   logic     mem_we;
   addr_type mem_waddr;
   cnt_type  mem_wdata;
   addr_type rd_addr;

   addr_type walk_ff;
   addr_type key_ff;
   logic     last_ff;
   logic     cnt_ok_ff;
   cnt_type  items_ff;
   logic     ovf_ff;
   cnt_type  emitted_ff;
   cnt_type  left_ff;
   logic     rsp_tvalid_ff;
   key_type  rsp_key_ff;
   logic     rsp_last_ff;
   logic     rsp_drop_ff;

   addr_type req_addr;
   logic     key_oor;
   logic     count_it;
   cnt_type  emitted_nx;

   assign req_addr   = KEY_BITS'(req_tdata);
   // Keys beyond the key range exist only when KEY_BITS is below the field width.
   assign key_oor    = (KEY_BITS < KEY_W) && ((req_tdata >> KEY_BITS) != '0);
   assign count_it   = !key_oor && (items_ff < CNT_BITS'(MAX_ITEMS));
   assign emitted_nx = CNT_BITS'(emitted_ff + 1'b1);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_key_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_drop_ff;

   // Memory port control. A read that meets a write to the same slot returns
   // the old count; no such read data is ever used.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = walk_ff;
      mem_wdata = '0;
      rd_addr   = walk_ff;
      case (state_ff)
         S_CLR: begin
            mem_we = 1'b1;
         end
         S_IDLE: begin
            rd_addr = req_addr;
         end
         S_INC: begin
            mem_we    = cnt_ok_ff;
            mem_waddr = key_ff;
            mem_wdata = CNT_BITS'(rdata_ff + 1'b1);
         end
         S_CHK: begin
            if (rdata_ff != '0) begin
               mem_we = 1'b1;   // clear the slot as it drains
            end else begin
               rd_addr = KEY_BITS'(walk_ff + 1'b1);
            end
         end
         S_EMIT: begin
            rd_addr = KEY_BITS'(walk_ff + 1'b1);
         end
         default: begin
            rd_addr = walk_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_counts_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= key_counts_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLR;
         walk_ff       <= '0;
         items_ff      <= '0;
         ovf_ff        <= 1'b0;
         emitted_ff    <= '0;
         left_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_CLR: begin
               walk_ff <= KEY_BITS'(walk_ff + 1'b1);
               if (&walk_ff) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_tvalid) begin
                  key_ff    <= req_addr;
                  last_ff   <= req_tlast;
                  cnt_ok_ff <= count_it;
                  state_ff  <= S_INC;
               end
            end
            S_INC: begin
               if (cnt_ok_ff) begin
                  items_ff <= CNT_BITS'(items_ff + 1'b1);
               end else begin
                  ovf_ff <= 1'b1;
               end
               if (!last_ff) begin
                  state_ff <= S_IDLE;
               end else if (items_ff == '0 && !cnt_ok_ff) begin
                  // empty set: nothing to emit, drop the overflow mark
                  ovf_ff   <= 1'b0;
                  state_ff <= S_IDLE;
               end else begin
                  walk_ff    <= '0;
                  emitted_ff <= '0;
                  state_ff   <= S_WALK;
               end
            end
            S_WALK: begin
               state_ff <= S_CHK;
            end
            S_CHK: begin
               if (rdata_ff != '0) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_key_ff    <= KEY_W'(walk_ff);
                  rsp_last_ff   <= (emitted_nx == items_ff);
                  rsp_drop_ff   <= ovf_ff;
                  left_ff       <= CNT_BITS'(rdata_ff - 1'b1);
                  emitted_ff    <= emitted_nx;
                  state_ff      <= S_EMIT;
               end else begin
                  walk_ff <= KEY_BITS'(walk_ff + 1'b1);
               end
            end
            S_EMIT: begin
               if (rsp_tready) begin
                  if (rsp_last_ff) begin
                     // set done: slots past the walk are already zero
                     rsp_tvalid_ff <= 1'b0;
                     items_ff      <= '0;
                     ovf_ff        <= 1'b0;
                     state_ff      <= S_IDLE;
                  end else if (left_ff != '0) begin
                     rsp_last_ff <= (emitted_nx == items_ff);
                     left_ff     <= CNT_BITS'(left_ff - 1'b1);
                     emitted_ff  <= emitted_nx;
                  end else begin
                     // advance to the next slot; its read is in flight
                     rsp_tvalid_ff <= 1'b0;
                     walk_ff       <= KEY_BITS'(walk_ff + 1'b1);
                     state_ff      <= S_CHK;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule : counting_sort

`default_nettype wire

@@ rtl/core/csort_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module csort_checker (
   input wire                 clock,
   input wire                 reset,
   input wire                 req_tvalid,
   input wire                 req_tready,
   input wire                 req_tlast,
   input wire                 rsp_tvalid,
   input wire                 rsp_tready,
   input csort_pkg::key_type  rsp_tdata,
   input wire                 rsp_tlast,
   input wire                 rsp_tuser
);

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // No key is taken while a set drains.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready during drain");

   // A key that does not close the set produces no result right after.
   a_quiet_load: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tlast |=> !rsp_tvalid)
      else $error("result after a non-last key");

   // The final result ends the drain.
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid)
      else $error("result after the final one");

endmodule : csort_checker

bind counting_sort csort_checker u_csort_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

@@ tb/tb_counting_sort.sv @@
`timescale 1ns / 1ps

// One sorted key as it should leave the rsp_ channel.
typedef struct packed {
   csort_pkg::key_type key;
   logic               last;
   logic               dropped;
} sorted_entry_type;

// Track the key tallies of the set being loaded. On the transaction flagged
// last, expand the tallies into the ascending sequence that must come out,
// then compare every rsp_ transaction against the oldest entry.
class sort_scoreboard;
   csort_pkg::cnt_type key_tally[csort_pkg::KEY_RANGE];
   int unsigned        set_size;
   bit                 set_overflow;
   sorted_entry_type   sorted_q[$];
   int unsigned        error_count;

   function new();
      error_count = 0;
      clear_set();
   endfunction

   function void clear_set();
      foreach (key_tally[i]) key_tally[i] = '0;
      set_size     = 0;
      set_overflow = 1'b0;
   endfunction

   // Cap the printout; keep counting past the cap.
   task report_mismatch(string what);
      error_count++;
      if (error_count <= 40) begin
         $display("[%0t] sort check: %s", $realtime, what);
      end
   endtask

   // Tally one accepted key; on the last key of a set, build the sorted output.
   function void note_key(csort_pkg::key_type key, logic is_last);
      int unsigned      emitted;
      sorted_entry_type entry;
      emitted = 0;
      // Drop keys outside the key range or beyond set capacity.
      if (int'(key) >= csort_pkg::KEY_RANGE || set_size >= csort_pkg::MAX_ITEMS) begin
         set_overflow = 1'b1;
      end else begin
         key_tally[key[csort_pkg::KEY_BITS-1:0]]++;
         set_size++;
      end
      if (is_last) begin
         for (int v = 0; v < csort_pkg::KEY_RANGE; v++) begin
            for (int c = 0; c < int'(key_tally[v]); c++) begin
               entry.key     = csort_pkg::key_type'(v);
               entry.last    = (emitted + 1 == set_size);
               entry.dropped = set_overflow;
               sorted_q.push_back(entry);
               emitted++;
            end
         end
         clear_set();
      end
   endfunction

   task check_sorted(csort_pkg::key_type key, logic last, logic dropped);
      sorted_entry_type want;
      if (sorted_q.size() == 0) begin
         report_mismatch($sformatf("unexpected key %0d last %0b dropped %0b",
                                   key, last, dropped));
      end else begin
         want = sorted_q.pop_front();
         if (key !== want.key) begin
            report_mismatch($sformatf("sorted_key %0d, want %0d", key, want.key));
         end
         if (last !== want.last) begin
            report_mismatch($sformatf("last_out %0b, want %0b on key %0d",
                                      last, want.last, want.key));
         end
         if (dropped !== want.dropped) begin
            report_mismatch($sformatf("dropped %0b, want %0b on key %0d",
                                      dropped, want.dropped, want.key));
         end
      end
   endtask
endclass

module tb_counting_sort;
   import csort_pkg::*;

   // Allow the reset clearing pass, a full empty-slot walk and long stalls.
   localparam int IDLE_LIMIT  = 4000;
   localparam int SETTLE_TIME = 400;
   localparam int KEY_TARGET  = 470;

   logic    clock      = 1'b0;
   logic    reset      = 1'b1;
   logic    req_tvalid = 1'b0;
   logic    req_tready;
   key_type req_tdata  = '0;     // [7:0] key
   logic    req_tlast  = 1'b0;   // is_last
   logic    rsp_tvalid;
   logic    rsp_tready = 1'b0;
   key_type rsp_tdata;           // [7:0] sorted_key
   logic    rsp_tlast;           // last_out
   logic    rsp_tuser;           // [0] dropped

   sort_scoreboard sb = new();

   int unsigned keys_sent   = 0;
   int unsigned burst_left  = 0;
   bit          steady_feed = 1'b0;
   int unsigned idle_cycles = 0;

   counting_sort i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Present one key at a falling edge and hold it until the block takes it.
   // Run in bursts; between bursts drop tvalid for a random gap unless the
   // current set is fed steadily.
   task automatic send_key(input key_type key, input logic is_last);
      if (burst_left == 0) begin
         if (!steady_feed) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(8, 20) : $urandom_range(1, 5))
               @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= key;
      req_tlast  <= is_last;
      do @(posedge clock); while (!req_tready);
      sb.note_key(key, is_last);
      keys_sent++;
      @(negedge clock);
   endtask

   // Send a set of n keys drawn from lo..hi; the final key carries is_last.
   task automatic send_set(input int n, input int lo, input int hi);
      steady_feed = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < n; i++) begin
         send_key(key_type'($urandom_range(lo, hi)), i == n - 1);
      end
   endtask

   // Receiver: switch stall pattern now and then, from always ready to
   // scattered random stalls to long holds.
   initial begin
      int unsigned mode;
      int unsigned mode_left;
      int unsigned hold_left;
      mode      = 0;
      mode_left = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 120);
         end
         mode_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (mode == 1) begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end else if (mode == 2 && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(1, 9);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Check every rsp_ transaction; restart the idle watchdog on any transaction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_sorted(rsp_tdata, rsp_tlast, rsp_tuser);
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == IDLE_LIMIT) begin
         $display("[%0t] no transaction for %0d cycles", $realtime, IDLE_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      key_type spread_keys[$];
      int      kind;
      int      lo;
      spread_keys = '{8'hFF, 8'h00, 8'hAA, 8'h55, 8'h00, 8'h80, 8'h7F, 8'hFF};

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: single-key sets at both ends of the key range.
      send_key(8'h00, 1'b1);
      send_key(8'hFF, 1'b1);
      // Duplicates at both ends, alternating bit patterns, unsorted order.
      foreach (spread_keys[i]) begin
         send_key(spread_keys[i], i == spread_keys.size() - 1);
      end
      // One bit set in each position, then a repeat to close the set.
      for (int b = 0; b < KEY_W; b++) begin
         send_key(key_type'(1 << b), 1'b0);
      end
      send_key(8'h01, 1'b1);

      // Random sets: mostly small, some with heavy duplicates, and a few that
      // fill the set exactly or run past capacity so the tail keys drop.
      while (keys_sent < KEY_TARGET) begin
         kind = $urandom_range(0, 99);
         if (kind < 65) begin
            send_set($urandom_range(1, 16), 0, 255);
         end else if (kind < 82) begin
            lo = $urandom_range(0, 255);
            send_set($urandom_range(2, 24), lo, (lo + 3 > 255) ? 255 : lo + 3);
         end else if (kind < 88) begin
            send_set(MAX_ITEMS, 0, 255);
         end else if (kind < 94) begin
            send_set($urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 8), 0, 255);
         end else begin
            send_set($urandom_range(1, 3), 0, 1);
         end
      end
      req_tvalid <= 1'b0;

      // Drain all expected keys, then let the block settle.
      while (sb.sorted_q.size() != 0) @(posedge clock);
      repeat (SETTLE_TIME) @(posedge clock);

      if (sb.error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
